// File: rtl/cbf_pkg.sv
// package: item types, status codes and escape marks for the byte offset decoder
package cbf_pkg;

  // field widths
  localparam int COUNT_WIDTH      = 24;
  localparam int BYTE_COUNT_WIDTH = 28;
  localparam int VALUE_WIDTH      = 32;
  localparam int STATUS_WIDTH     = 3;

  // default depth of the result queue (power of two, at least 4)
  localparam int OUT_DEPTH_DEFAULT = 8;

  // result status codes
  localparam logic [STATUS_WIDTH-1:0] ST_VALUE    = 3'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_END_OK   = 3'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_EARLY    = 3'd2;
  localparam logic [STATUS_WIDTH-1:0] ST_OVERFLOW = 3'd3;
  localparam logic [STATUS_WIDTH-1:0] ST_TRAILING = 3'd4;

  // escape levels: delta width 8, 16, 32, 64 bits
  localparam logic [1:0] LVL_8  = 2'd0;
  localparam logic [1:0] LVL_16 = 2'd1;
  localparam logic [1:0] LVL_32 = 2'd2;
  localparam logic [1:0] LVL_64 = 2'd3;

  // escape marks of the narrower delta widths
  localparam logic [63:0] MARK_8  = 64'h0000_0000_0000_0080;
  localparam logic [63:0] MARK_16 = 64'h0000_0000_0000_8000;
  localparam logic [63:0] MARK_32 = 64'h0000_0000_8000_0000;

  // input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       carries_byte;
    logic       is_last;
  } in_item_t;

  // result item
  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [STATUS_WIDTH-1:0]       status;
    logic                          final_flag;
    logic [BYTE_COUNT_WIDTH-1:0]   bytes_consumed;
  } out_item_t;

endpackage

// File: rtl/cbf_byte_offset_decoder_core.sv
// top level: byte offset delta decoder with input register and result queue
//
// One compressed byte enters per item on in_valid/in_ready; the decoded
// cumulative values and the closing status leave on out_valid/out_ready.
// The element count is written on cfg_valid/cfg_ready (always ready); the user
// must write it only while the stream is idle; the block does not enforce it.
// An accepted item is held in an input register, decoded there against
// the stream state, and its zero, one or two results are written into a
// result queue of OUT_DEPTH entries, from which they are offered.
// One item is taken every cycle as long as the queue can still hold two
// results on top of those of the item in the input register, so the
// sustained rate is one item per cycle when the receiver takes a result
// every cycle; the wide escape delta add and range check sits in the
// decode of the input register.
// When the receiver stalls, results collect in the queue and in_ready
// drops once fewer than two free entries remain for a new item.
// Synchronous reset empties the queue and the input register, clears the
// stream state and sets the element count to zero. After a final result
// the stream state returns to its reset value; the element count is kept.
module cbf_byte_offset_decoder_core #(
  parameter int OUT_DEPTH = cbf_pkg::OUT_DEPTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  cbf_pkg::in_item_t                    in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output cbf_pkg::out_item_t                   out_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cbf_pkg::COUNT_WIDTH-1:0]      cfg_data
);

  localparam int AW  = $clog2(OUT_DEPTH);
  localparam int CW  = cbf_pkg::COUNT_WIDTH;
  localparam int BCW = cbf_pkg::BYTE_COUNT_WIDTH;

  // configuration register
  logic [CW-1:0] element_count;

  // input register
  logic              stage_valid;
  cbf_pkg::in_item_t stage_item;

  // stream state
  logic [1:0]          escape_level, escape_level_next;
  logic [2:0]          group_byte_index, group_byte_index_next;
  logic [63:0]         delta_assembly, delta_assembly_next;
  logic signed [31:0]  running_sum, running_sum_next;
  logic [CW-1:0]       elements_done, elements_done_next;
  logic [BCW-1:0]      byte_counter, byte_counter_next;
  logic                error_latched, error_latched_next;
  logic                trailing_seen, trailing_seen_next;

  // result queue
  cbf_pkg::out_item_t queue [OUT_DEPTH];
  logic [AW-1:0]      rd_ptr, wr_ptr;
  logic [AW:0]        fill;

  // decode signals
  logic                     take, produced, group_done, is_escape;
  logic [2:0]               group_last;
  logic [63:0]              asm_new, escape_mark;
  logic signed [64:0]       delta, sum_wide;
  logic                     overflow;
  logic [2:0]               status;
  logic [1:0]               push_count;
  cbf_pkg::out_item_t       res0, res1;
  logic                     pop;

  assign cfg_ready = 1'b1;

  // keep room for two results beyond those of the item in the input register
  assign in_ready  = ({1'b0, fill} + {{AW{1'b0}}, stage_valid, 1'b0})
                     <= (AW + 2)'(OUT_DEPTH - 2);
  assign out_valid = (fill != '0);
  assign out_item  = queue[rd_ptr];
  assign pop       = out_valid && out_ready;

  // per-level group length and escape mark
  always_comb begin
    unique case (escape_level)
      cbf_pkg::LVL_8: begin
        group_last  = 3'd0;
        escape_mark = cbf_pkg::MARK_8;
      end
      cbf_pkg::LVL_16: begin
        group_last  = 3'd1;
        escape_mark = cbf_pkg::MARK_16;
      end
      cbf_pkg::LVL_32: begin
        group_last  = 3'd3;
        escape_mark = cbf_pkg::MARK_32;
      end
      default: begin
        group_last  = 3'd7;
        escape_mark = '0;
      end
    endcase
  end

  // byte insertion and delta sign extension
  always_comb begin
    asm_new = delta_assembly
              | ({56'd0, stage_item.data_byte} << {group_byte_index, 3'b000});
    unique case (escape_level)
      cbf_pkg::LVL_8:  delta = {{57{asm_new[7]}}, asm_new[7:0]};
      cbf_pkg::LVL_16: delta = {{49{asm_new[15]}}, asm_new[15:0]};
      cbf_pkg::LVL_32: delta = {{33{asm_new[31]}}, asm_new[31:0]};
      default:         delta = {asm_new[63], asm_new};
    endcase
    sum_wide = {{33{running_sum[31]}}, running_sum} + delta;
    overflow = !((&sum_wide[64:31]) || !(|sum_wide[64:31]));
  end

  assign take       = stage_valid && stage_item.carries_byte && !error_latched
                      && (elements_done < element_count);
  assign group_done = (group_byte_index == group_last);
  assign is_escape  = (escape_level != cbf_pkg::LVL_64) && (asm_new == escape_mark);
  assign produced   = take && group_done && !is_escape && !overflow;

  // state update for the item in the input register
  always_comb begin
    escape_level_next     = escape_level;
    group_byte_index_next = group_byte_index;
    delta_assembly_next   = delta_assembly;
    running_sum_next      = running_sum;
    elements_done_next    = elements_done;
    byte_counter_next     = byte_counter;
    error_latched_next    = error_latched;
    trailing_seen_next    = trailing_seen;
    if (stage_valid && stage_item.carries_byte && !error_latched && !take) begin
      trailing_seen_next = 1'b1;
    end
    if (take) begin
      if (byte_counter != '1) begin
        byte_counter_next = byte_counter + 1'b1;
      end
      if (!group_done) begin
        group_byte_index_next = group_byte_index + 3'd1;
        delta_assembly_next   = asm_new;
      end else if (is_escape) begin
        escape_level_next     = escape_level + 2'd1;
        group_byte_index_next = '0;
        delta_assembly_next   = '0;
      end else begin
        escape_level_next     = cbf_pkg::LVL_8;
        group_byte_index_next = '0;
        delta_assembly_next   = '0;
        if (overflow) begin
          error_latched_next = 1'b1;
        end else begin
          running_sum_next   = sum_wide[31:0];
          elements_done_next = elements_done + 1'b1;
        end
      end
    end
  end

  // closing status, from the updated state
  always_comb begin
    if (error_latched_next) begin
      status = cbf_pkg::ST_OVERFLOW;
    end else if ((elements_done_next < element_count) || (escape_level_next != '0)
                 || (group_byte_index_next != '0)) begin
      status = cbf_pkg::ST_EARLY;
    end else if (trailing_seen_next) begin
      status = cbf_pkg::ST_TRAILING;
    end else begin
      status = cbf_pkg::ST_END_OK;
    end
  end

  // results of the item
  always_comb begin
    res0.value          = running_sum_next;
    res0.status         = cbf_pkg::ST_VALUE;
    res0.final_flag     = 1'b0;
    res0.bytes_consumed = '0;
    res1.value          = (status == cbf_pkg::ST_END_OK) ? running_sum_next : '0;
    res1.status         = status;
    res1.final_flag     = 1'b1;
    res1.bytes_consumed = byte_counter_next;
    push_count          = 2'd0;
    if (stage_valid) begin
      if (!stage_item.is_last) begin
        push_count = produced ? 2'd1 : 2'd0;
      end else if (produced && status == cbf_pkg::ST_END_OK) begin
        res0       = res1;
        push_count = 2'd1;
      end else if (produced) begin
        push_count = 2'd2;
      end else begin
        res0       = res1;
        push_count = 2'd1;
      end
    end
  end

  // control and stream state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count    <= '0;
      stage_valid      <= 1'b0;
      escape_level     <= cbf_pkg::LVL_8;
      group_byte_index <= '0;
      delta_assembly   <= '0;
      running_sum      <= '0;
      elements_done    <= '0;
      byte_counter     <= '0;
      error_latched    <= 1'b0;
      trailing_seen    <= 1'b0;
      rd_ptr           <= '0;
      wr_ptr           <= '0;
      fill             <= '0;
    end else begin
      if (cfg_valid) begin
        element_count <= cfg_data;
      end
      stage_valid <= in_valid && in_ready;
      if (stage_valid && stage_item.is_last) begin
        escape_level     <= cbf_pkg::LVL_8;
        group_byte_index <= '0;
        delta_assembly   <= '0;
        running_sum      <= '0;
        elements_done    <= '0;
        byte_counter     <= '0;
        error_latched    <= 1'b0;
        trailing_seen    <= 1'b0;
      end else begin
        escape_level     <= escape_level_next;
        group_byte_index <= group_byte_index_next;
        delta_assembly   <= delta_assembly_next;
        running_sum      <= running_sum_next;
        elements_done    <= elements_done_next;
        byte_counter     <= byte_counter_next;
        error_latched    <= error_latched_next;
        trailing_seen    <= trailing_seen_next;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      wr_ptr <= wr_ptr + AW'(push_count);
      fill   <= fill + (AW + 1)'(push_count) - (AW + 1)'(pop);
    end
  end

  // input register payload and result queue storage
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_item;
    end
    if (push_count != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (push_count == 2'd2) begin
      queue[wr_ptr + 1'b1] <= res1;
    end
  end

endmodule
